/* design/sfp_pkg.sv */
// sfp_pkg: shared types, constants and the crc-16 byte update for the sync frame parser
// no dependencies; used by the interfaces, sfp_parser and sync_frame_parser_crc16_top
package sfp_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_PROTO_ERR = 2'd2;
  localparam logic [1:0] ST_LEN_ERR   = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd5;

  localparam int POS_SYNC2   = 1;
  localparam int POS_VERSION = 2;
  localparam int POS_TYPE    = 3;
  localparam int POS_SEQ     = 4;
  localparam int POS_LEN     = 5;
  localparam int POS_PAYLOAD = 6;
  localparam int CMD_BYTES   = 5;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] protocol_version;
    logic [7:0] command_frame_type;
    logic [5:0] command_payload_len;
    logic [5:0] max_payload_len;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_first:          8'hAA,
    sync_second:         8'h55,
    protocol_version:    8'h01,
    command_frame_type:  8'h01,
    command_payload_len: 6'd5,
    max_payload_len:     6'd56
  };

  typedef struct packed {
    logic [1:0]         frame_status;
    logic [7:0]         frame_sequence;
    logic [7:0]         command_code;
    logic signed [31:0] command_value;
    logic [31:0]        crc_error_count;
    logic [31:0]        protocol_error_count;
    logic [31:0]        valid_frame_count;
  } result_t;

  typedef struct packed {
    logic    hit;
    result_t data;
  } parse_res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* design/sfp_if.sv */
// sfp_if: valid/ready channel interfaces for bytes in, frame results out and register writes
// depends on sfp_pkg
interface sfp_in_if import sfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if import sfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [7:0]         frame_sequence;
  logic [7:0]         command_code;
  logic signed [31:0] command_value;
  logic [31:0]        crc_error_count;
  logic [31:0]        protocol_error_count;
  logic [31:0]        valid_frame_count;

  modport source (output valid, output frame_status, output frame_sequence,
                  output command_code, output command_value, output crc_error_count,
                  output protocol_error_count, output valid_frame_count, input ready);
  modport sink   (input valid, input frame_status, input frame_sequence,
                  input command_code, input command_value, input crc_error_count,
                  input protocol_error_count, input valid_frame_count, output ready);
endinterface

interface sfp_cfg_if import sfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/sfp_parser.sv */
// sfp_parser: frame state, field capture, running crc and error/valid counters
// depends on sfp_pkg; instantiated by sync_frame_parser_crc16_top
module sfp_parser import sfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output parse_res_t res
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EW = ((CW > 8) ? CW : 8) + 1;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    ver_r, ver_nxt;
  logic [7:0]    typ_r, typ_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    crclo_r, crclo_nxt;
  logic [7:0]    pay_r   [CMD_BYTES];
  logic [7:0]    pay_nxt [CMD_BYTES];
  logic [31:0]   crc_cnt_r, crc_cnt_nxt;
  logic [31:0]   prot_cnt_r, prot_cnt_nxt;
  logic [31:0]   val_cnt_r, val_cnt_nxt;

  logic [EW-1:0] fill_x;
  logic [EW-1:0] len_x;
  logic [7:0]    len_cur;
  logic [15:0]   crc_upd;
  logic [15:0]   rx_crc;
  logic [7:0]    pb [CMD_BYTES];

  assign fill_x  = EW'(fill_r);
  assign len_cur = (fill_x == EW'(POS_LEN)) ? rx_byte : len_r;
  assign len_x   = EW'(len_cur);
  assign crc_upd = crc16_byte((fill_x == EW'(POS_VERSION)) ? CRC_INIT : crc_r, rx_byte);
  assign rx_crc  = {rx_byte, crclo_r};

  always_comb begin
    for (int k = 0; k < CMD_BYTES; k++) begin
      pb[k] = (len_r > 8'(k)) ? pay_r[k] : 8'h00;
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    crc_nxt      = crc_r;
    ver_nxt      = ver_r;
    typ_nxt      = typ_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    crclo_nxt    = crclo_r;
    pay_nxt      = pay_r;
    crc_cnt_nxt  = crc_cnt_r;
    prot_cnt_nxt = prot_cnt_r;
    val_cnt_nxt  = val_cnt_r;
    res          = '0;

    priority if (fill_x == '0) begin
      if (rx_byte == cfg.sync_first) fill_nxt = CW'(1);
    end else if (fill_x == EW'(POS_SYNC2)) begin
      if (rx_byte == cfg.sync_second)     fill_nxt = CW'(2);
      else if (rx_byte == cfg.sync_first) fill_nxt = CW'(1);
      else                                fill_nxt = '0;
    end else if (fill_x >= EW'(MAX_FRAME_BYTES)) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = fill_r + CW'(1);
      if (fill_x == EW'(POS_VERSION)) ver_nxt = rx_byte;
      if (fill_x == EW'(POS_TYPE))    typ_nxt = rx_byte;
      if (fill_x == EW'(POS_SEQ))     seq_nxt = rx_byte;
      if (fill_x == EW'(POS_LEN))     len_nxt = rx_byte;
      for (int k = 0; k < CMD_BYTES; k++) begin
        if (fill_x == EW'(POS_PAYLOAD + k)) pay_nxt[k] = rx_byte;
      end

      priority if (fill_x < EW'(POS_LEN)) begin
        crc_nxt = crc_upd;
      end else if (len_cur > {2'b00, cfg.max_payload_len}) begin
        fill_nxt                       = '0;
        prot_cnt_nxt                   = prot_cnt_r + 32'd1;
        res.hit                        = 1'b1;
        res.data.frame_status          = ST_LEN_ERR;
      end else if (fill_x <= EW'(POS_LEN) + len_x) begin
        crc_nxt = crc_upd;
      end else if (fill_x == EW'(POS_PAYLOAD) + len_x) begin
        crclo_nxt = rx_byte;
      end else begin
        fill_nxt                = '0;
        res.hit                 = 1'b1;
        res.data.frame_sequence = seq_r;
        priority if (rx_crc != crc_r) begin
          crc_cnt_nxt           = crc_cnt_r + 32'd1;
          res.data.frame_status = ST_CRC_ERR;
        end else if (ver_r == cfg.protocol_version && typ_r == cfg.command_frame_type &&
                     len_r == {2'b00, cfg.command_payload_len}) begin
          val_cnt_nxt            = val_cnt_r + 32'd1;
          res.data.frame_status  = ST_VALID;
          res.data.command_code  = pb[0];
          res.data.command_value = {pb[4], pb[3], pb[2], pb[1]};
        end else begin
          prot_cnt_nxt          = prot_cnt_r + 32'd1;
          res.data.frame_status = ST_PROTO_ERR;
        end
      end
    end

    res.data.crc_error_count      = crc_cnt_nxt;
    res.data.protocol_error_count = prot_cnt_nxt;
    res.data.valid_frame_count    = val_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      crc_r      <= CRC_INIT;
      crc_cnt_r  <= '0;
      prot_cnt_r <= '0;
      val_cnt_r  <= '0;
    end else if (accept) begin
      fill_r     <= fill_nxt;
      crc_r      <= crc_nxt;
      crc_cnt_r  <= crc_cnt_nxt;
      prot_cnt_r <= prot_cnt_nxt;
      val_cnt_r  <= val_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ver_r   <= ver_nxt;
      typ_r   <= typ_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      crclo_r <= crclo_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule

/* design/sync_frame_parser_crc16_top.sv */
// Byte-serial frame receiver: hunts for two sync bytes, collects version, type,
// sequence, length, payload and a little-endian CRC-16/MODBUS, and reports each
// finished frame (valid command, crc error, protocol mismatch or oversize length)
// with wrapping error and valid counters. One byte is taken every clock cycle unless the
// input stalls; the crc update is a single unrolled 8-bit step between the frame state and
// the result register, so a result shows in the cycle after the byte that ends the frame.
// Input stalls only while a result sits in the output register and is not taken.
// Registers are written through the cfg channel, which is always ready.
// depends on sfp_pkg, sfp_if and sfp_parser
module sync_frame_parser_crc16_top import sfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  sfp_in_if.sink           in_ch,
  sfp_out_if.source        out_ch,
  sfp_cfg_if.sink          cfg_ch
);

  cfg_t       cfg_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       in_fire;
  parse_res_t res;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  sfp_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SYNC_FIRST:  cfg_r.sync_first          <= cfg_ch.data;
        REG_SYNC_SECOND: cfg_r.sync_second         <= cfg_ch.data;
        REG_VERSION:     cfg_r.protocol_version    <= cfg_ch.data;
        REG_FRAME_TYPE:  cfg_r.command_frame_type  <= cfg_ch.data;
        REG_CMD_LEN:     cfg_r.command_payload_len <= cfg_ch.data[5:0];
        REG_MAX_LEN:     cfg_r.max_payload_len     <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.hit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.hit) begin
      out_r <= res.data;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.frame_status         = out_r.frame_status;
  assign out_ch.frame_sequence       = out_r.frame_sequence;
  assign out_ch.command_code         = out_r.command_code;
  assign out_ch.command_value        = out_r.command_value;
  assign out_ch.crc_error_count      = out_r.crc_error_count;
  assign out_ch.protocol_error_count = out_r.protocol_error_count;
  assign out_ch.valid_frame_count    = out_r.valid_frame_count;

endmodule

/* tb/frame_checker.sv */
`timescale 1ns / 100ps
// frame_checker: tracks register writes and received bytes, predicts each frame result
// of the sync frame parser and compares the result transactions field by field
// depends on sfp_pkg
module frame_checker import sfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  result_t              out_result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   pending,
  output int                   mismatches
);

  cfg_t        regs;
  logic [7:0]  frame_mem [0:MAX_FRAME_BYTES-1];
  int unsigned fill;
  logic [15:0] crc_acc;
  logic [31:0] crc_errs;
  logic [31:0] proto_errs;
  logic [31:0] good_frames;
  result_t     frame_results [$];
  result_t     oldest;

  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] mem_at(input int unsigned idx);
    return (idx < MAX_FRAME_BYTES) ? frame_mem[idx] : 8'h00;
  endfunction

  function automatic logic [7:0] payload_at(input int unsigned k, input int unsigned len);
    return (k < len) ? mem_at(POS_PAYLOAD + k) : 8'h00;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic post_result(input result_t r);
    r.crc_error_count      = crc_errs;
    r.protocol_error_count = proto_errs;
    r.valid_frame_count    = good_frames;
    frame_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t     r;
    int unsigned len;
    logic [15:0] rx_crc;
    r = '0;
    if (fill == 0) begin
      if (b == regs.sync_first) begin
        frame_mem[0] = b;
        fill = 1;
      end
      return;
    end
    if (fill == 1) begin
      if (b == regs.sync_second) begin
        frame_mem[POS_SYNC2] = b;
        fill = 2;
      end else begin
        fill = (b == regs.sync_first) ? 1 : 0;
      end
      return;
    end
    // store full: byte dropped, back to hunting
    if (fill >= MAX_FRAME_BYTES) begin
      fill = 0;
      return;
    end
    frame_mem[fill] = b;
    if (fill == POS_VERSION) crc_acc = CRC_INIT;
    fill++;
    if (fill <= POS_LEN) begin
      crc_acc = crc_update(crc_acc, b);
      return;
    end
    len = mem_at(POS_LEN);
    if (len > regs.max_payload_len) begin
      proto_errs++;
      fill = 0;
      r.frame_status = ST_LEN_ERR;
      post_result(r);
      return;
    end
    if (fill <= POS_PAYLOAD + len) begin
      crc_acc = crc_update(crc_acc, b);
      return;
    end
    if (fill < POS_PAYLOAD + 2 + len) return;
    rx_crc = {mem_at(POS_PAYLOAD + 1 + len), mem_at(POS_PAYLOAD + len)};
    r.frame_sequence = mem_at(POS_SEQ);
    if (rx_crc != crc_acc) begin
      crc_errs++;
      r.frame_status = ST_CRC_ERR;
    end else if (mem_at(POS_VERSION) == regs.protocol_version &&
                 mem_at(POS_TYPE) == regs.command_frame_type &&
                 len == regs.command_payload_len) begin
      good_frames++;
      r.frame_status  = ST_VALID;
      r.command_code  = payload_at(0, len);
      r.command_value = {payload_at(4, len), payload_at(3, len),
                         payload_at(2, len), payload_at(1, len)};
    end else begin
      proto_errs++;
      r.frame_status = ST_PROTO_ERR;
    end
    fill = 0;
    post_result(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs        = CFG_RESET;
      fill        = 0;
      crc_acc     = CRC_INIT;
      crc_errs    = '0;
      proto_errs  = '0;
      good_frames = '0;
      frame_results.delete();
      mismatches  = 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          report("result transaction with no frame pending");
        end else begin
          oldest = frame_results.pop_front();
          check_field("frame_status", 32'(out_result.frame_status), 32'(oldest.frame_status));
          check_field("frame_sequence", 32'(out_result.frame_sequence),
                      32'(oldest.frame_sequence));
          check_field("command_code", 32'(out_result.command_code), 32'(oldest.command_code));
          check_field("command_value", out_result.command_value, oldest.command_value);
          check_field("crc_error_count", out_result.crc_error_count, oldest.crc_error_count);
          check_field("protocol_error_count", out_result.protocol_error_count,
                      oldest.protocol_error_count);
          check_field("valid_frame_count", out_result.valid_frame_count,
                      oldest.valid_frame_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:  regs.sync_first          = cfg_data;
          REG_SYNC_SECOND: regs.sync_second         = cfg_data;
          REG_VERSION:     regs.protocol_version    = cfg_data;
          REG_FRAME_TYPE:  regs.command_frame_type  = cfg_data;
          REG_CMD_LEN:     regs.command_payload_len = cfg_data[5:0];
          REG_MAX_LEN:     regs.max_payload_len     = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      pending <= frame_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives frames, noise and broken syncs into sync_frame_parser_crc16_top under
// several register settings and idle profiles; frame_checker does the checking
// depends on sfp_pkg, sfp_if, frame_checker and the parser rtl
module testbench;
  import sfp_pkg::*;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n;
  cfg_t       cur_cfg;
  int         snd_idle_pct;
  int         rcv_idle_pct;
  int         quiet_cycles = 0;
  int         bytes_sent = 0;
  int         pending;
  int         mismatches;
  logic [7:0] pay [0:255];

  sfp_in_if  in_ch ();
  sfp_out_if out_ch ();
  sfp_cfg_if cfg_ch ();

  always #1 clk = ~clk;

  sync_frame_parser_crc16_top #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_rx_byte (in_ch.rx_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result ({out_ch.frame_status, out_ch.frame_sequence, out_ch.command_code,
                  out_ch.command_value, out_ch.crc_error_count,
                  out_ch.protocol_error_count, out_ch.valid_frame_count}),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] frame_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input cfg_t c);
    settle();
    write_reg(REG_SYNC_FIRST, c.sync_first);
    write_reg(REG_SYNC_SECOND, c.sync_second);
    write_reg(REG_VERSION, c.protocol_version);
    write_reg(REG_FRAME_TYPE, c.command_frame_type);
    write_reg(REG_CMD_LEN, {2'b00, c.command_payload_len});
    write_reg(REG_MAX_LEN, {2'b00, c.max_payload_len});
    cur_cfg = c;
  endtask

  // payload and crc are skipped when the length byte is already oversize
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ, input logic [7:0] seq,
                            input logic [7:0] len, input bit bad_crc);
    logic [15:0] c;
    send_byte(cur_cfg.sync_first);
    send_byte(cur_cfg.sync_second);
    c = CRC_INIT;
    c = frame_crc_step(c, ver);
    c = frame_crc_step(c, typ);
    c = frame_crc_step(c, seq);
    c = frame_crc_step(c, len);
    send_byte(ver);
    send_byte(typ);
    send_byte(seq);
    send_byte(len);
    if (len > cur_cfg.max_payload_len) return;
    for (int k = 0; k < len; k++) begin
      c = frame_crc_step(c, pay[k]);
      send_byte(pay[k]);
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic rand_sequence();
    int          pick;
    int          hi;
    logic [7:0]  len;
    logic [7:0]  ver;
    logic [7:0]  typ;
    pick = $urandom_range(0, 99);
    hi   = cur_cfg.max_payload_len;
    for (int k = 0; k < 256; k++) pay[k] = 8'($urandom);
    ver = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_cfg.protocol_version;
    typ = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_cfg.command_frame_type;
    if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       len = 8'(cur_cfg.command_payload_len);
        3:       len = 8'($urandom_range(0, hi));
        default: len = 8'($urandom_range(0, (hi < 8) ? hi : 8));
      endcase
      send_frame(ver, typ, 8'($urandom), len, $urandom_range(0, 99) < 15);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (pick < 92) begin
      send_byte(cur_cfg.sync_first);
      send_byte(($urandom_range(0, 3) == 0) ? cur_cfg.sync_first : 8'($urandom));
    end else begin
      send_frame(ver, typ, 8'($urandom), 8'($urandom_range(hi + 1, 255)), 1'b0);
    end
  endtask

  task automatic run_random(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) rand_sequence();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_SYNC_FIRST;
    cfg_ch.data   = 8'h00;
    cur_cfg       = CFG_RESET;
    snd_idle_pct  = 6;
    rcv_idle_pct  = 66;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: sync mismatch with resync, value extremes, each status
    send_byte(cur_cfg.sync_first);
    send_byte(8'h13);
    pay[0] = 8'hFF; pay[1] = 8'h00; pay[2] = 8'h00; pay[3] = 8'h00; pay[4] = 8'h80;
    send_frame(cur_cfg.protocol_version, cur_cfg.command_frame_type, 8'hFF, 8'd5, 1'b0);
    pay[0] = 8'h00; pay[1] = 8'hFF; pay[2] = 8'hFF; pay[3] = 8'hFF; pay[4] = 8'h7F;
    send_frame(cur_cfg.protocol_version, cur_cfg.command_frame_type, 8'h00, 8'd5, 1'b0);
    send_frame(8'hFE, cur_cfg.command_frame_type, 8'h5A, 8'd0, 1'b0);
    send_frame(cur_cfg.protocol_version, cur_cfg.command_frame_type, 8'hA5, 8'd0, 1'b1);
    send_frame(cur_cfg.protocol_version, cur_cfg.command_frame_type, 8'h01, 8'hFF, 1'b0);
    run_random(120);

    snd_idle_pct = 66;
    rcv_idle_pct = 6;
    set_regs('{sync_first: 8'h00, sync_second: 8'hFF, protocol_version: 8'hFF,
               command_frame_type: 8'h00, command_payload_len: 6'd2, max_payload_len: 6'd4});
    write_reg(REG_SPARE_A, 8'h5C);
    // command payload shorter than code plus value
    pay[0] = 8'hC3; pay[1] = 8'h81;
    send_frame(8'hFF, 8'h00, 8'h42, 8'd2, 1'b0);
    run_random(100);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_regs('{sync_first: 8'hFF, sync_second: 8'h00, protocol_version: 8'h00,
               command_frame_type: 8'hFF, command_payload_len: 6'd56, max_payload_len: 6'd63});
    write_reg(REG_SPARE_B, 8'hFF);
    for (int k = 0; k < 256; k++) pay[k] = 8'($urandom);
    send_frame(8'h00, 8'hFF, 8'h77, 8'd56, 1'b0);
    // frame outgrows the store
    send_frame(8'h00, 8'hFF, 8'h78, 8'd60, 1'b0);
    run_random(70);

    set_regs('{sync_first: 8'hAA, sync_second: 8'h55, protocol_version: 8'h01,
               command_frame_type: 8'h01, command_payload_len: 6'd5, max_payload_len: 6'd0});
    run_random(50);

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
design/sfp_pkg.sv
design/sfp_if.sv
design/sfp_parser.sv
design/sync_frame_parser_crc16_top.sv
tb/frame_checker.sv
tb/testbench.sv
